// ===== rtl/clr_pkg.sv =====
// shared constants and job descriptor types for the clipped line rasterizer
`default_nettype none

package clr_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;
  localparam int MAX_PIXELS    = 64;

  localparam int IN_W    = 16;
  localparam int COORD_W = 10;
  localparam int STEP_W  = 8;
  localparam int FRAC_W  = 16;
  localparam int OFF_W   = FRAC_W + 1;
  localparam int ACC_W   = COORD_W + FRAC_W;
  localparam int IDX_W   = $clog2(MAX_PIXELS);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // command mode codes, the last one draws nothing
  localparam logic [1:0] MODE_LINE = 2'd0;
  localparam logic [1:0] MODE_HDOT = 2'd1;
  localparam logic [1:0] MODE_VDOT = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef enum logic {
    JOB_AXIS,
    JOB_DDA
  } job_kind_t;

  // one drawing job handed from the front to the pixel stepper
  typedef struct packed {
    job_kind_t          kind;
    logic               major_is_y;
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] major_end;
    logic               major_down;
    logic [COORD_W-1:0] minor;
    logic [COORD_W-1:0] minor_end;
    logic               minor_down;
    logic [STEP_W-1:0]  step;
    logic [OFF_W-1:0]   off;
    logic               color;
  } clr_job_t;

endpackage

`default_nettype wire

// ===== rtl/clipped_line_rasterizer_core.sv =====
// line rasterizer top: a dotted run goes through the classify and push states, a solid run
// also through setup, and a sloped line through setup and the slope divider before push
// pixels leave at one word per cycle while out_stall is low, up to 64 per command
// the front end stalls the next command until the last is rejected or pushed, as the queue allows
// reset is synchronous and active low: it empties the queue and clears all handshake state
`default_nettype none

module clipped_line_rasterizer_core import clr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic signed [IN_W-1:0] in_start_x,
  input  logic signed [IN_W-1:0] in_start_y,
  input  logic signed [IN_W-1:0] in_end_x,
  input  logic signed [IN_W-1:0] in_end_y,
  input  logic [STEP_W-1:0]      in_dot_step,
  input  logic                   in_pen_color,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_W-1:0]     out_pixel_x,
  output logic [COORD_W-1:0]     out_pixel_y,
  output logic                   out_pixel_color,
  output logic                   out_last_pixel
);

  logic               div_start;
  logic [COORD_W-1:0] div_num;
  logic [COORD_W-1:0] div_den;
  logic               div_done;
  logic [OFF_W-1:0]   div_quot;
  logic               q_push;
  clr_job_t           q_job;
  logic               q_full;
  logic               q_pop;
  clr_job_t           q_head;
  logic               q_empty;

  clr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .in_dot_step  (in_dot_step),
    .in_pen_color (in_pen_color),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .q_push       (q_push),
    .q_job        (q_job),
    .q_full       (q_full)
  );

  clr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  clr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  clr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

`default_nettype wire

// ===== rtl/clr_div.sv =====
// restoring divider for the dda slope, one quotient bit per cycle
`default_nettype none

module clr_div import clr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] num,
  input  logic [COORD_W-1:0] den,
  output logic               done,
  output logic [OFF_W-1:0]   quot
);

  localparam int CNT_W = $clog2(OFF_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] rem_r;
  logic [OFF_W-1:0]   dbit_r;
  logic [COORD_W-1:0] den_r;
  logic [OFF_W-1:0]   quot_r;

  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;
  logic               ge;

  // dividend is num << 16, so only num[0] and zeros remain below the first remainder
  assign trial = {rem_r, dbit_r[OFF_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(OFF_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num >> 1;
      dbit_r <= {num[0], {(OFF_W-1){1'b0}}};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      dbit_r <= dbit_r << 1;
      quot_r <= {quot_r[OFF_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/clr_front.sv =====
// command front end: accept, order, reject or clamp, and build a drawing job
`default_nettype none

module clr_front import clr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic signed [IN_W-1:0] in_start_x,
  input  logic signed [IN_W-1:0] in_start_y,
  input  logic signed [IN_W-1:0] in_end_x,
  input  logic signed [IN_W-1:0] in_end_y,
  input  logic [STEP_W-1:0]      in_dot_step,
  input  logic                   in_pen_color,
  output logic                   div_start,
  output logic [COORD_W-1:0]     div_num,
  output logic [COORD_W-1:0]     div_den,
  input  logic                   div_done,
  input  logic [OFF_W-1:0]       div_quot,
  output logic                   q_push,
  output clr_job_t               q_job,
  input  logic                   q_full
);

  localparam logic signed [IN_W-1:0] SCR_W_S = IN_W'(SCREEN_WIDTH);
  localparam logic signed [IN_W-1:0] SCR_H_S = IN_W'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_SETUP,
    S_DIV,
    S_PUSH
  } state_t;

  state_t                 state_r;
  logic [1:0]             mode_r;
  logic signed [IN_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [STEP_W-1:0]      step_r;
  logic                   color_r;
  logic [COORD_W-1:0]     x0_r, y0_r, x1_r, y1_r;
  clr_job_t               job_r;

  // general line ordering and clamping
  logic                   swap;
  logic signed [IN_W-1:0] gx0, gy0, gx1, gy1;
  logic                   g_reject;
  logic [COORD_W-1:0]     cx0, cy0, cx1, cy1;

  // dotted line ordering and clamping
  logic                   d_horiz;
  logic signed [IN_W-1:0] d_fixed, d_p, d_q, d_lo, d_hi, d_lim, d_flim;
  logic [COORD_W-1:0]     d_lim_m1, d_lo_c, d_hi_c;
  logic                   d_reject;
  logic [STEP_W-1:0]      d_step;
  clr_job_t               d_job;

  // job setup from clamped general endpoints
  logic [COORD_W-1:0]     s_dx, s_dy;
  logic                   s_ydown, s_shallow, s_is_axis;
  clr_job_t               s_job;

  always_comb begin
    swap     = sx_r > ex_r;
    gx0      = swap ? ex_r : sx_r;
    gy0      = swap ? ey_r : sy_r;
    gx1      = swap ? sx_r : ex_r;
    gy1      = swap ? sy_r : ey_r;
    g_reject = (gy0 >= SCR_H_S) || (gx0 >= SCR_W_S) || gy1[IN_W-1] || gx1[IN_W-1];
    cx0      = gx0[IN_W-1] ? '0 : gx0[COORD_W-1:0];
    cy0      = gy0[IN_W-1] ? '0 : gy0[COORD_W-1:0];
    cx1      = (gx1 >= SCR_W_S) ? COORD_W'(SCREEN_WIDTH - 1) : gx1[COORD_W-1:0];
    cy1      = (gy1 >= SCR_H_S) ? COORD_W'(SCREEN_HEIGHT - 1) : gy1[COORD_W-1:0];
  end

  always_comb begin
    d_horiz  = mode_r == MODE_HDOT;
    d_fixed  = d_horiz ? sy_r : sx_r;
    d_p      = d_horiz ? sx_r : sy_r;
    d_q      = d_horiz ? ex_r : ey_r;
    d_lo     = (d_p > d_q) ? d_q : d_p;
    d_hi     = (d_p > d_q) ? d_p : d_q;
    d_lim    = d_horiz ? SCR_W_S : SCR_H_S;
    d_flim   = d_horiz ? SCR_H_S : SCR_W_S;
    d_lim_m1 = d_horiz ? COORD_W'(SCREEN_WIDTH - 1) : COORD_W'(SCREEN_HEIGHT - 1);
    d_reject = d_fixed[IN_W-1] || (d_fixed >= d_flim) || d_hi[IN_W-1] || (d_lo >= d_lim);
    d_lo_c   = d_lo[IN_W-1] ? '0 : d_lo[COORD_W-1:0];
    d_hi_c   = (d_hi >= d_lim) ? d_lim_m1 : d_hi[COORD_W-1:0];
    d_step   = (step_r == '0) ? STEP_W'(1) : step_r;

    d_job             = '0;
    d_job.kind        = JOB_AXIS;
    d_job.major_is_y  = !d_horiz;
    d_job.major_start = d_lo_c;
    d_job.major_end   = d_hi_c;
    d_job.minor       = d_fixed[COORD_W-1:0];
    d_job.step        = d_step;
    d_job.color       = color_r;
  end

  always_comb begin
    s_dx      = x1_r - x0_r;
    s_ydown   = y1_r < y0_r;
    s_dy      = s_ydown ? (y0_r - y1_r) : (y1_r - y0_r);
    s_shallow = s_dy < s_dx;
    s_is_axis = (x0_r == x1_r) || (y0_r == y1_r);

    s_job       = '0;
    s_job.step  = STEP_W'(1);
    s_job.color = color_r;
    if (x0_r == x1_r) begin
      // vertical solid run
      s_job.kind        = JOB_AXIS;
      s_job.major_is_y  = 1'b1;
      s_job.major_start = s_ydown ? y1_r : y0_r;
      s_job.major_end   = s_ydown ? y0_r : y1_r;
      s_job.minor       = x0_r;
    end else if (y0_r == y1_r) begin
      s_job.kind        = JOB_AXIS;
      s_job.major_is_y  = 1'b0;
      s_job.major_start = x0_r;
      s_job.major_end   = x1_r;
      s_job.minor       = y0_r;
    end else if (s_shallow) begin
      s_job.kind        = JOB_DDA;
      s_job.major_is_y  = 1'b0;
      s_job.major_start = x0_r;
      s_job.major_end   = x1_r;
      s_job.minor       = y0_r;
      s_job.minor_end   = y1_r;
      s_job.minor_down  = s_ydown;
    end else begin
      // steep: column accumulator always rises toward the end column
      s_job.kind        = JOB_DDA;
      s_job.major_is_y  = 1'b1;
      s_job.major_start = y0_r;
      s_job.major_end   = y1_r;
      s_job.major_down  = s_ydown;
      s_job.minor       = x0_r;
      s_job.minor_end   = x1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            sx_r    <= in_start_x;
            sy_r    <= in_start_y;
            ex_r    <= in_end_x;
            ey_r    <= in_end_y;
            step_r  <= in_dot_step;
            color_r <= in_pen_color;
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          case (mode_r)
            MODE_LINE: begin
              x0_r    <= cx0;
              y0_r    <= cy0;
              x1_r    <= cx1;
              y1_r    <= cy1;
              state_r <= g_reject ? S_IDLE : S_SETUP;
            end
            MODE_HDOT, MODE_VDOT: begin
              job_r   <= d_job;
              state_r <= d_reject ? S_IDLE : S_PUSH;
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end
        S_SETUP: begin
          job_r   <= s_job;
          state_r <= s_is_axis ? S_PUSH : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            job_r.off <= div_quot;
            state_r   <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign div_start = (state_r == S_SETUP) && !s_is_axis;
  assign div_num   = s_shallow ? s_dy : s_dx;
  assign div_den   = s_shallow ? s_dx : s_dy;
  assign q_push    = (state_r == S_PUSH) && !q_full;
  assign q_job     = job_r;

endmodule

`default_nettype wire

// ===== rtl/clr_queue.sv =====
// short job queue between the front end and the pixel stepper
`default_nettype none

module clr_queue import clr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  clr_job_t push_job,
  output logic     full,
  input  logic     pop,
  output clr_job_t head,
  output logic     empty
);

  clr_job_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign full  = count_r == QCNT_W'(QDEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/clr_back.sv =====
// pixel stepper: walks one job a pixel per cycle into the output register, unless a stalled output word holds it
`default_nettype none

module clr_back import clr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  clr_job_t           q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic               out_pixel_color,
  output logic               out_last_pixel
);

  clr_job_t           job_r;
  logic               busy_r;
  logic [COORD_W-1:0] major_r;
  logic [ACC_W-1:0]   acc_r;
  logic [IDX_W-1:0]   idx_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] pix_x_r;
  logic [COORD_W-1:0] pix_y_r;
  logic               pix_color_r;
  logic               pix_last_r;

  logic               load;
  logic               fire;
  logic [COORD_W-1:0] minor_int;
  logic [COORD_W:0]   axis_sum;
  logic               end_hit;
  logic               is_last;
  logic [ACC_W-1:0]   endv;
  logic [ACC_W:0]     off_ext;
  logic [ACC_W:0]     acc_up;
  logic [ACC_W:0]     endv_off;
  logic [ACC_W-1:0]   acc_nxt;
  logic [COORD_W-1:0] major_nxt;

  assign load = !busy_r && !q_empty;
  assign fire = busy_r && (!out_valid_r || !out_stall);

  always_comb begin
    minor_int = (job_r.kind == JOB_AXIS) ? job_r.minor : acc_r[ACC_W-1:FRAC_W];
    axis_sum  = {1'b0, major_r} + {{(COORD_W+1-STEP_W){1'b0}}, job_r.step};
    end_hit   = (job_r.kind == JOB_AXIS) ? (axis_sum > {1'b0, job_r.major_end})
                                         : (major_r == job_r.major_end);
    is_last   = end_hit || (idx_r == IDX_W'(MAX_PIXELS - 1));

    endv     = {job_r.minor_end, {FRAC_W{1'b0}}};
    off_ext  = {{(ACC_W+1-OFF_W){1'b0}}, job_r.off};
    acc_up   = {1'b0, acc_r} + off_ext;
    endv_off = {1'b0, endv} + off_ext;
    // descending minor clamps once the next step would reach or pass the end
    if (job_r.minor_down) begin
      acc_nxt = ({1'b0, acc_r} <= endv_off) ? endv : (acc_r - off_ext[ACC_W-1:0]);
    end else begin
      acc_nxt = (acc_up > {1'b0, endv}) ? endv : acc_up[ACC_W-1:0];
    end

    if (job_r.kind == JOB_AXIS) begin
      major_nxt = axis_sum[COORD_W-1:0];
    end else if (job_r.major_down) begin
      major_nxt = major_r - COORD_W'(1);
    end else begin
      major_nxt = major_r + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r   <= q_head;
      major_r <= q_head.major_start;
      acc_r   <= {q_head.minor, {FRAC_W{1'b0}}};
      idx_r   <= '0;
    end else if (fire) begin
      major_r <= major_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_r + IDX_W'(1);
    end
    if (fire) begin
      pix_x_r     <= job_r.major_is_y ? minor_int : major_r;
      pix_y_r     <= job_r.major_is_y ? major_r : minor_int;
      pix_color_r <= job_r.color;
      pix_last_r  <= is_last;
    end
  end

  assign q_pop           = load;
  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_pixel_color = pix_color_r;
  assign out_last_pixel  = pix_last_r;

endmodule

`default_nettype wire
